FILE: rtl/uvsvg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsvg_pkg
// Shared widths, register codes, reset values and the CORDIC angle table
// for the UV-sphere vertex generator.
// ----------------------------------------------------------------------------
package uvsvg_pkg;

   // field widths
   localparam int RADIUS_W   = 16;
   localparam int COUNT_W    = 13;
   localparam int INDEX_W    = 13;
   localparam int POS_W      = 17;
   localparam int NORM_W     = 16;
   localparam int TEX_W      = 17;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS  = 2'd0,
      CSR_SECTORS = 2'd1,
      CSR_STACKS  = 2'd2
   } csr_index_type;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 16'd256;
   localparam logic [COUNT_W-1:0]  SECTORS_RESET = 13'd36;
   localparam logic [COUNT_W-1:0]  STACKS_RESET  = 13'd18;

   // parameter defaults
   localparam int DEFAULT_MAX_COUNT       = 4096;
   localparam int DEFAULT_TRIG_ITERATIONS = 16;
   localparam int ATAN_ENTRIES            = 24;

   // cordic datapath: vector in Q1.30 with headroom, angle in 2^-32 turns
   localparam int TRIG_W  = 34;
   localparam int ANGLE_W = 33;
   localparam int TRIG_OUT_W = 32;

   localparam logic signed [TRIG_W-1:0] CORDIC_START = 34'sd652032875;

   // atan(2^-k) in 2^-32 turn units
   function automatic logic signed [ANGLE_W-1:0] atan_turn(input int k);
      logic signed [ANGLE_W-1:0] a;
      case (k)
         0:  a = 33'sd536870912;
         1:  a = 33'sd316933406;
         2:  a = 33'sd167458907;
         3:  a = 33'sd85004756;
         4:  a = 33'sd42667331;
         5:  a = 33'sd21354465;
         6:  a = 33'sd10679838;
         7:  a = 33'sd5340245;
         8:  a = 33'sd2670163;
         9:  a = 33'sd1335087;
         10: a = 33'sd667544;
         11: a = 33'sd333772;
         12: a = 33'sd166886;
         13: a = 33'sd83443;
         14: a = 33'sd41722;
         15: a = 33'sd20861;
         16: a = 33'sd10430;
         17: a = 33'sd5215;
         18: a = 33'sd2608;
         19: a = 33'sd1304;
         20: a = 33'sd652;
         21: a = 33'sd326;
         22: a = 33'sd163;
         23: a = 33'sd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

FILE: rtl/uv_sphere_vertex_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_unit
// Streams one UV-sphere vertex (position, normal, texture coords) per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries a stack index and a sector index per beat; the rsp
//   channel returns one vertex beat for each request, in order. A beat moves
//   when valid is high and stall is low on that channel.
//   csr port writes radius (index 0), sector count (1) and stack count (2);
//   write only while no request is in flight.
// Pipeline: the beat passes TRIG_ITERATIONS + 24 register stages: one input
//   stage, 17 stages of a bit-per-stage divider for the texture fractions,
//   one phase stage, one stage per CORDIC iteration, a fold-back stage, two
//   multiply stages and two rounding stages ending in the output register.
// Throughput: one beat per cycle unless stalled; the whole pipeline
//   advances together.
// Stall: while rsp_stall holds a waiting result, every stage holds and
//   req_stall is raised; nothing is dropped or repeated.
// Reset: clears all valid bits and loads radius 256, 36 sectors, 18 stacks.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_unit #(
   parameter int MAX_COUNT       = uvsvg_pkg::DEFAULT_MAX_COUNT,
   parameter int TRIG_ITERATIONS = uvsvg_pkg::DEFAULT_TRIG_ITERATIONS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic        [uvsvg_pkg::INDEX_W-1:0]   req_stack_index,
   input  logic        [uvsvg_pkg::INDEX_W-1:0]   req_sector_index,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [uvsvg_pkg::POS_W-1:0]     rsp_pos_x,
   output logic signed [uvsvg_pkg::POS_W-1:0]     rsp_pos_y,
   output logic signed [uvsvg_pkg::POS_W-1:0]     rsp_pos_z,
   output logic signed [uvsvg_pkg::NORM_W-1:0]    rsp_norm_x,
   output logic signed [uvsvg_pkg::NORM_W-1:0]    rsp_norm_y,
   output logic signed [uvsvg_pkg::NORM_W-1:0]    rsp_norm_z,
   output logic        [uvsvg_pkg::TEX_W-1:0]     rsp_tex_s,
   output logic        [uvsvg_pkg::TEX_W-1:0]     rsp_tex_t,
   output logic                                   rsp_index_clamped,
   // configuration port
   input  logic                                   csr_write_en,
   input  logic        [uvsvg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [uvsvg_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int CW    = uvsvg_pkg::COUNT_W;
   localparam int REM_W = CW + 1;
   localparam int DIV_N = uvsvg_pkg::TEX_W;
   localparam int TW    = uvsvg_pkg::TRIG_W;
   localparam int AW    = uvsvg_pkg::ANGLE_W;
   localparam int OW    = uvsvg_pkg::TRIG_OUT_W;
   localparam int PW    = 2 * OW;
   localparam int RW    = uvsvg_pkg::RADIUS_W + 1 + OW;
   localparam int ITER  = (TRIG_ITERATIONS < uvsvg_pkg::ATAN_ENTRIES) ?
                          TRIG_ITERATIONS : uvsvg_pkg::ATAN_ENTRIES;

   localparam logic signed [PW-1:0] HALF_P  = PW'(64'sd1 <<< 29);
   localparam logic signed [RW-1:0] HALF_R  = RW'(64'sd1 <<< 29);
   localparam logic signed [OW-1:0] HALF_N  = OW'(32'sd1 <<< 15);
   localparam logic signed [RW-31:0] POS_LIM  = (RW-30)'(65535);
   localparam logic signed [OW-17:0] NORM_LIM = (OW-16)'(16384);

   // values that travel alongside the cordic lanes
   typedef struct packed {
      logic [uvsvg_pkg::TEX_W-1:0] tex_s;
      logic [uvsvg_pkg::TEX_W-1:0] tex_t;
      logic                        clamped;
      logic                        flip_s;
      logic                        flip_t;
   } aux_type;

   // configuration registers
   logic [uvsvg_pkg::RADIUS_W-1:0] radius_ff;
   logic [CW-1:0]                  sectors_ff;
   logic [CW-1:0]                  stacks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= uvsvg_pkg::RADIUS_RESET;
         sectors_ff <= uvsvg_pkg::SECTORS_RESET;
         stacks_ff  <= uvsvg_pkg::STACKS_RESET;
      end else if (csr_write_en) begin
         unique case (uvsvg_pkg::csr_index_type'(csr_index))
            uvsvg_pkg::CSR_RADIUS:  radius_ff  <= csr_data[uvsvg_pkg::RADIUS_W-1:0];
            uvsvg_pkg::CSR_SECTORS: sectors_ff <= csr_data[CW-1:0];
            uvsvg_pkg::CSR_STACKS:  stacks_ff  <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   // counts limited to [1, MAX_COUNT]
   function automatic logic [CW-1:0] eff_count(input logic [CW-1:0] c);
      logic [CW-1:0] r;
      if (c == '0) r = CW'(1);
      else if (32'(c) > 32'(MAX_COUNT)) r = CW'(MAX_COUNT);
      else r = c;
      return r;
   endfunction

   logic [CW-1:0] eff_sectors;
   logic [CW-1:0] eff_stacks;
   assign eff_sectors = eff_count(sectors_ff);
   assign eff_stacks  = eff_count(stacks_ff);

   // global advance: hold everything while a finished beat is stalled
   logic adv;
   logic out_vld_ff;
   assign adv       = !out_vld_ff || !rsp_stall;
   assign req_stall = !adv;

   // ------------------------------------------------------------------
   // input stage and divider: tex = (index << 16) / count, one bit a stage
   // ------------------------------------------------------------------
   logic             div_vld_ff [DIV_N+1];
   logic [REM_W-1:0] rs_ff      [DIV_N+1];
   logic [REM_W-1:0] rt_ff      [DIV_N+1];
   logic [DIV_N-1:0] qs_ff      [DIV_N+1];
   logic [DIV_N-1:0] qt_ff      [DIV_N+1];
   logic             cl_ff      [DIV_N+1];
   logic             bs_ff;
   logic             bt_ff;

   logic [CW-1:0] j_c;
   logic [CW-1:0] i_c;
   logic          clamp_in;
   always_comb begin
      j_c = (req_sector_index > eff_sectors) ? eff_sectors : req_sector_index;
      i_c = (req_stack_index > eff_stacks) ? eff_stacks : req_stack_index;
      clamp_in = (req_sector_index > eff_sectors) || (req_stack_index > eff_stacks);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         div_vld_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rs_ff[0] <= REM_W'(j_c >> 1);
         rt_ff[0] <= REM_W'(i_c >> 1);
         bs_ff    <= j_c[0];
         bt_ff    <= i_c[0];
         qs_ff[0] <= '0;
         qt_ff[0] <= '0;
         cl_ff[0] <= clamp_in;
      end
   end

   function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                              input logic b,
                                              input logic [CW-1:0] d);
      logic [REM_W-1:0] sh;
      logic             q;
      sh = {rem[REM_W-2:0], b};
      q  = (sh >= REM_W'(d));
      if (q) sh = sh - REM_W'(d);
      return {q, sh};
   endfunction

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      logic [REM_W:0] st_s;
      logic [REM_W:0] st_t;
      logic           in_s;
      logic           in_t;

      // only the first step brings in a nonzero dividend bit
      always_comb begin
         in_s = (k == 0) ? bs_ff : 1'b0;
         in_t = (k == 0) ? bt_ff : 1'b0;
         st_s = div_step(rs_ff[k], in_s, eff_sectors);
         st_t = div_step(rt_ff[k], in_t, eff_stacks);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            div_vld_ff[k+1] <= div_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rs_ff[k+1] <= st_s[REM_W-1:0];
            rt_ff[k+1] <= st_t[REM_W-1:0];
            qs_ff[k+1] <= {qs_ff[k][DIV_N-2:0], st_s[REM_W]};
            qt_ff[k+1] <= {qt_ff[k][DIV_N-2:0], st_t[REM_W]};
            cl_ff[k+1] <= cl_ff[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // phase stage: turn fractions into angles, fold into the right half
   // ------------------------------------------------------------------
   logic                 cv_ff  [ITER+1];
   logic signed [TW-1:0] sxs_ff [ITER+1];
   logic signed [TW-1:0] sys_ff [ITER+1];
   logic signed [AW-1:0] szs_ff [ITER+1];
   logic signed [TW-1:0] sxt_ff [ITER+1];
   logic signed [TW-1:0] syt_ff [ITER+1];
   logic signed [AW-1:0] szt_ff [ITER+1];
   aux_type              aux_ff [ITER+1];

   logic [31:0] ph_s;
   logic [31:0] ph_t;
   logic [31:0] ph_s_f;
   logic [31:0] ph_t_f;
   logic [31:0] chk_s;
   logic [31:0] chk_t;
   aux_type     aux_in;

   always_comb begin
      ph_s  = {qs_ff[DIV_N][15:0], 16'd0};
      ph_t  = 32'h4000_0000 - {qt_ff[DIV_N], 15'd0};
      chk_s = ph_s + 32'h4000_0000;
      chk_t = ph_t + 32'h4000_0000;
      aux_in.tex_s   = qs_ff[DIV_N];
      aux_in.tex_t   = qt_ff[DIV_N];
      aux_in.clamped = cl_ff[DIV_N];
      aux_in.flip_s  = chk_s[31];
      aux_in.flip_t  = chk_t[31];
      ph_s_f = chk_s[31] ? (ph_s - 32'h8000_0000) : ph_s;
      ph_t_f = chk_t[31] ? (ph_t - 32'h8000_0000) : ph_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= div_vld_ff[DIV_N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sxs_ff[0] <= uvsvg_pkg::CORDIC_START;
         sys_ff[0] <= '0;
         szs_ff[0] <= AW'($signed(ph_s_f));
         sxt_ff[0] <= uvsvg_pkg::CORDIC_START;
         syt_ff[0] <= '0;
         szt_ff[0] <= AW'($signed(ph_t_f));
         aux_ff[0] <= aux_in;
      end
   end

   // ------------------------------------------------------------------
   // cordic rotation, one iteration a stage, sector and stack lanes
   // ------------------------------------------------------------------
   for (genvar k = 0; k < ITER; k++) begin : g_cordic
      logic signed [AW-1:0] at;
      assign at = uvsvg_pkg::atan_turn(k);

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[k+1] <= cv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (!szs_ff[k][AW-1]) begin
               sxs_ff[k+1] <= sxs_ff[k] - (sys_ff[k] >>> k);
               sys_ff[k+1] <= sys_ff[k] + (sxs_ff[k] >>> k);
               szs_ff[k+1] <= szs_ff[k] - at;
            end else begin
               sxs_ff[k+1] <= sxs_ff[k] + (sys_ff[k] >>> k);
               sys_ff[k+1] <= sys_ff[k] - (sxs_ff[k] >>> k);
               szs_ff[k+1] <= szs_ff[k] + at;
            end
            if (!szt_ff[k][AW-1]) begin
               sxt_ff[k+1] <= sxt_ff[k] - (syt_ff[k] >>> k);
               syt_ff[k+1] <= syt_ff[k] + (sxt_ff[k] >>> k);
               szt_ff[k+1] <= szt_ff[k] - at;
            end else begin
               sxt_ff[k+1] <= sxt_ff[k] + (syt_ff[k] >>> k);
               syt_ff[k+1] <= syt_ff[k] - (sxt_ff[k] >>> k);
               szt_ff[k+1] <= szt_ff[k] + at;
            end
            aux_ff[k+1] <= aux_ff[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // fold back: undo the half-turn move by negation
   // ------------------------------------------------------------------
   logic                 post_vld_ff;
   logic signed [OW-1:0] cst_ff, sst_ff, csc_ff, ssc_ff;
   aux_type              post_aux_ff;
   logic signed [TW-1:0] cst_in, sst_in, csc_in, ssc_in;

   always_comb begin
      csc_in = aux_ff[ITER].flip_s ? -sxs_ff[ITER] : sxs_ff[ITER];
      ssc_in = aux_ff[ITER].flip_s ? -sys_ff[ITER] : sys_ff[ITER];
      cst_in = aux_ff[ITER].flip_t ? -sxt_ff[ITER] : sxt_ff[ITER];
      sst_in = aux_ff[ITER].flip_t ? -syt_ff[ITER] : syt_ff[ITER];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= 1'b0;
      end else if (adv) begin
         post_vld_ff <= cv_ff[ITER];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cst_ff      <= OW'(cst_in);
         sst_ff      <= OW'(sst_in);
         csc_ff      <= OW'(csc_in);
         ssc_ff      <= OW'(ssc_in);
         post_aux_ff <= aux_ff[ITER];
      end
   end

   // ------------------------------------------------------------------
   // normal products cos(stack) times cos/sin(sector)
   // ------------------------------------------------------------------
   logic                 m1_vld_ff;
   logic signed [PW-1:0] px_ff, py_ff;
   logic signed [OW-1:0] m1_nz_ff;
   aux_type              m1_aux_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else if (adv) begin
         m1_vld_ff <= post_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff     <= PW'(cst_ff * csc_ff);
         py_ff     <= PW'(cst_ff * ssc_ff);
         m1_nz_ff  <= sst_ff;
         m1_aux_ff <= post_aux_ff;
      end
   end

   // round products back to Q1.30
   logic                 m2_vld_ff;
   logic signed [OW-1:0] n_ff [3];
   aux_type              m2_aux_ff;
   logic signed [PW-1:0] rx, ry;

   always_comb begin
      rx = (px_ff + HALF_P) >>> 30;
      ry = (py_ff + HALF_P) >>> 30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else if (adv) begin
         m2_vld_ff <= m1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff[0]   <= OW'(rx);
         n_ff[1]   <= OW'(ry);
         n_ff[2]   <= m1_nz_ff;
         m2_aux_ff <= m1_aux_ff;
      end
   end

   // ------------------------------------------------------------------
   // radius products and normal rounding
   // ------------------------------------------------------------------
   logic                     m3_vld_ff;
   logic signed [RW-1:0]     pr_ff [3];
   logic signed [uvsvg_pkg::NORM_W-1:0] qn_ff [3];
   aux_type                  m3_aux_ff;
   logic signed [uvsvg_pkg::NORM_W-1:0] qn_in [3];
   logic signed [RW-1:0]     pr_in [3];
   logic signed [uvsvg_pkg::RADIUS_W:0] rad_s;

   assign rad_s = $signed({1'b0, radius_ff});

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic signed [OW-1:0]    nr;
         logic signed [OW-17:0]   nt;
         nr = (n_ff[a] + HALF_N) >>> 16;
         nt = (OW-16)'(nr);
         if (nt > NORM_LIM) nt = NORM_LIM;
         else if (nt < -NORM_LIM) nt = -NORM_LIM;
         qn_in[a] = uvsvg_pkg::NORM_W'(nt);
         pr_in[a] = RW'(rad_s * n_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_vld_ff <= 1'b0;
      end else if (adv) begin
         m3_vld_ff <= m2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            pr_ff[a] <= pr_in[a];
            qn_ff[a] <= qn_in[a];
         end
         m3_aux_ff <= m2_aux_ff;
      end
   end

   // ------------------------------------------------------------------
   // output register: round and saturate positions
   // ------------------------------------------------------------------
   logic signed [uvsvg_pkg::POS_W-1:0] pos_in [3];
   logic signed [uvsvg_pkg::POS_W-1:0] pos_ff [3];
   logic signed [uvsvg_pkg::NORM_W-1:0] nrm_ff [3];
   aux_type                             out_aux_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic signed [RW-1:0]  pw;
         logic signed [RW-31:0] pt;
         pw = (pr_ff[a] + HALF_R) >>> 30;
         pt = (RW-30)'(pw);
         if (pt > POS_LIM) pt = POS_LIM;
         else if (pt < -POS_LIM) pt = -POS_LIM;
         pos_in[a] = uvsvg_pkg::POS_W'(pt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= m3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            pos_ff[a] <= pos_in[a];
            nrm_ff[a] <= qn_ff[a];
         end
         out_aux_ff <= m3_aux_ff;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_pos_x         = pos_ff[0];
   assign rsp_pos_y         = pos_ff[1];
   assign rsp_pos_z         = pos_ff[2];
   assign rsp_norm_x        = nrm_ff[0];
   assign rsp_norm_y        = nrm_ff[1];
   assign rsp_norm_z        = nrm_ff[2];
   assign rsp_tex_s         = out_aux_ff.tex_s;
   assign rsp_tex_t         = out_aux_ff.tex_t;
   assign rsp_index_clamped = out_aux_ff.clamped;

endmodule

FILE: rtl/uvsvg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsvg_checker
// Port-level checks for the UV-sphere vertex generator, bound to the top.
// ----------------------------------------------------------------------------
module uvsvg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [uvsvg_pkg::NORM_W-1:0] rsp_norm_x,
   input logic signed [uvsvg_pkg::NORM_W-1:0] rsp_norm_z,
   input logic        [uvsvg_pkg::TEX_W-1:0]  rsp_tex_s
);

   // a stalled result beat holds its valid, its normal x and its texture s
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_norm_x) && $stable(rsp_tex_s))
      else $error("stalled result beat changed");

   // the request side only stalls behind a stalled result
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("request stalled without a stalled result");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // normal x, normal z and texture s stay within their ranges
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_norm_x <= 16'sd16384) && (rsp_norm_x >= -16'sd16384) &&
                    (rsp_norm_z <= 16'sd16384) && (rsp_norm_z >= -16'sd16384) &&
                    (rsp_tex_s <= 17'd65536))
      else $error("result field out of range");

endmodule

bind uv_sphere_vertex_generator_unit uvsvg_checker u_uvsvg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_norm_x (rsp_norm_x),
   .rsp_norm_z (rsp_norm_z),
   .rsp_tex_s  (rsp_tex_s)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UV-sphere vertex generator: an in-bench fixed
// point predictor (CORDIC, products, rounding, saturation) computes each
// vertex, and a checker compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LATENCY         = uvsvg_pkg::DEFAULT_TRIG_ITERATIONS + 24;
   localparam int CYCLE_LIMIT     = 900000;
   localparam int MAX_CNT         = uvsvg_pkg::DEFAULT_MAX_COUNT;
   localparam int HOLD_OFF_CYCLES = 200;
   // index that maps to no register
   localparam uvsvg_pkg::csr_index_type CSR_UNMAPPED = uvsvg_pkg::csr_index_type'('1);

   typedef struct packed {
      logic signed [uvsvg_pkg::POS_W-1:0]  pos_x, pos_y, pos_z;
      logic signed [uvsvg_pkg::NORM_W-1:0] norm_x, norm_y, norm_z;
      logic [uvsvg_pkg::TEX_W-1:0]         tex_s, tex_t;
      logic                                clamped;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [uvsvg_pkg::INDEX_W-1:0] req_stack_index = '0;
   logic [uvsvg_pkg::INDEX_W-1:0] req_sector_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [uvsvg_pkg::POS_W-1:0]  rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [uvsvg_pkg::NORM_W-1:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [uvsvg_pkg::TEX_W-1:0] rsp_tex_s, rsp_tex_t;
   logic rsp_index_clamped;
   logic csr_write_en = 1'b0;
   logic [uvsvg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [uvsvg_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // predictor copy of the registers
   longint radius_reg = uvsvg_pkg::RADIUS_RESET;
   longint sectors_reg = uvsvg_pkg::SECTORS_RESET;
   longint stacks_reg = uvsvg_pkg::STACKS_RESET;

   vertex_type expected_vertices[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_on = 1'b0;
   event hold_off_start;

   uv_sphere_vertex_generator_unit dut (.*);

   always #5 clock = ~clock;

   // floor shift on 64-bit signed values
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_half_up(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint count_in_range(longint c);
      if (c < 1) return 1;
      if (c > MAX_CNT) return MAX_CNT;
      return c;
   endfunction

   // rotation-mode cordic on a 32-bit turn fraction, cos and sin in Q1.30
   task automatic cos_sin(input logic [31:0] phase, output longint c, output longint s);
      logic [31:0] p;
      logic [31:0] chk;
      logic  flip;
      longint x, y, z, nx;
      p = phase;
      chk = p + 32'h4000_0000;
      flip = chk[31];
      x = uvsvg_pkg::CORDIC_START;
      y = 0;
      if (flip) p = p - 32'h8000_0000;
      z = longint'($signed(p));
      for (int k = 0; k < uvsvg_pkg::DEFAULT_TRIG_ITERATIONS && k < uvsvg_pkg::ATAN_ENTRIES;
           k++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, k);
            y = y + floor_shift(x, k);
            z = z - longint'(uvsvg_pkg::atan_turn(k));
         end else begin
            nx = x + floor_shift(y, k);
            y = y - floor_shift(x, k);
            z = z + longint'(uvsvg_pkg::atan_turn(k));
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endtask

   // expected vertex for one stack/sector pair
   task automatic predict_vertex(input longint stack_in, input longint sector_in,
                                 output vertex_type v);
      longint stacks, sectors, i, j, ts, tt, cst, sst, csc, ssc;
      longint n[3];
      logic [31:0] ph;
      stacks = count_in_range(stacks_reg);
      sectors = count_in_range(sectors_reg);
      i = stack_in;
      j = sector_in;
      v.clamped = 1'b0;
      if (i > stacks) begin i = stacks; v.clamped = 1'b1; end
      if (j > sectors) begin j = sectors; v.clamped = 1'b1; end
      ts = (j << 16) / sectors;
      tt = (i << 16) / stacks;
      ph = 32'h4000_0000 - 32'(tt << 15);
      cos_sin(ph, cst, sst);
      ph = 32'(ts << 16);
      cos_sin(ph, csc, ssc);
      n[0] = round_half_up(cst * csc, 30);
      n[1] = round_half_up(cst * ssc, 30);
      n[2] = sst;
      v.pos_x = uvsvg_pkg::POS_W'(clip(round_half_up(radius_reg * n[0], 30), 65535));
      v.pos_y = uvsvg_pkg::POS_W'(clip(round_half_up(radius_reg * n[1], 30), 65535));
      v.pos_z = uvsvg_pkg::POS_W'(clip(round_half_up(radius_reg * n[2], 30), 65535));
      v.norm_x = uvsvg_pkg::NORM_W'(clip(round_half_up(n[0], 16), 16384));
      v.norm_y = uvsvg_pkg::NORM_W'(clip(round_half_up(n[1], 16), 16384));
      v.norm_z = uvsvg_pkg::NORM_W'(clip(round_half_up(n[2], 16), 16384));
      v.tex_s = uvsvg_pkg::TEX_W'(ts);
      v.tex_t = uvsvg_pkg::TEX_W'(tt);
   endtask

   // sends one request beat and queues its expected vertex; valid stays up
   task automatic send_vertex_request(input int stack_in, input int sector_in);
      vertex_type v;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_stack_index <= uvsvg_pkg::INDEX_W'(stack_in);
      req_sector_index <= uvsvg_pkg::INDEX_W'(sector_in);
      predict_vertex(stack_in, sector_in, v);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_vertices.insert(expected_vertices.size(), v);
   endtask

   // drop valid and wait for every expected result
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_vertices.size() != 0) @(posedge clock);
   endtask

   task automatic wait_drained();
      pause_until_drained();
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // caller lowers csr_write_en after the last write
   task automatic write_register(input uvsvg_pkg::csr_index_type idx, input int value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= uvsvg_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      case (idx)
         uvsvg_pkg::CSR_RADIUS:  radius_reg = value & 32'hFFFF;
         uvsvg_pkg::CSR_SECTORS: sectors_reg = value & 32'h1FFF;
         uvsvg_pkg::CSR_STACKS:  stacks_reg = value & 32'h1FFF;
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int radius, input int sectors, input int stacks);
      wait_drained();
      write_register(uvsvg_pkg::CSR_RADIUS, radius);
      write_register(uvsvg_pkg::CSR_SECTORS, sectors);
      write_register(uvsvg_pkg::CSR_STACKS, stacks);
      csr_write_en <= 1'b0;
   endtask

   // long receiver hold-off, counted here
   initial begin
      forever begin
         @(hold_off_start);
         hold_on <= 1'b1;
         repeat (HOLD_OFF_CYCLES) @(posedge clock);
         hold_on <= 1'b0;
      end
   end

   // receiver stall generator
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= hold_on || ((recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct));
   end

   // result checker
   always @(posedge clock) begin
      vertex_type got, exp_v;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_norm_x, rsp_norm_y, rsp_norm_z,
                 rsp_tex_s, rsp_tex_t, rsp_index_clamped};
         if (expected_vertices.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result beat %p", got);
         end else begin
            exp_v = expected_vertices.pop_front();
            if (got !== exp_v) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("vertex mismatch: expected %p actual %p", exp_v, got);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // poles, equator, wrap-around and clamping at the reset geometry
   task automatic test_directed_reset_geometry();
      send_vertex_request(0, 0);
      send_vertex_request(18, 36);
      send_vertex_request(9, 9);
      send_vertex_request(9, 18);
      send_vertex_request(9, 27);
      send_vertex_request(3, 5);
      send_vertex_request(19, 0);
      send_vertex_request(0, 37);
      send_vertex_request(8191, 8191);
      send_vertex_request(4096, 4096);
   endtask

   // count extremes, zero and over-range counts, radius extremes
   task automatic test_directed_extremes();
      set_geometry(65535, 4096, 4096);
      send_vertex_request(2048, 1024);
      send_vertex_request(4095, 4095);
      send_vertex_request(1, 1);
      set_geometry(0, 0, 0);
      send_vertex_request(0, 0);
      send_vertex_request(1, 1);
      send_vertex_request(5, 0);
      set_geometry(1, 8191, 5000);
      send_vertex_request(4096, 3000);
      send_vertex_request(8191, 0);
      set_geometry(65535, 1, 2);
      send_vertex_request(1, 0);
      send_vertex_request(0, 1);
      send_vertex_request(2, 1);
      wait_drained();
      write_register(CSR_UNMAPPED, 16'hFFFF);
      csr_write_en <= 1'b0;
      send_vertex_request(1, 1);
   endtask

   task automatic random_phase(input int n);
      int stacks, sectors;
      stacks = count_in_range(stacks_reg);
      sectors = count_in_range(sectors_reg);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(9) == 0)
            send_vertex_request($urandom_range(8191), $urandom_range(8191));
         else
            send_vertex_request($urandom_range(stacks), $urandom_range(sectors));
      end
   endtask

   task automatic random_geometry();
      int r, s, t;
      case ($urandom_range(3))
         0: begin r = $urandom_range(65535); s = $urandom_range(8191);
               t = $urandom_range(8191); end
         1: begin r = $urandom_range(1024); s = $urandom_range(64);
               t = $urandom_range(64); end
         default: begin r = $urandom_range(65535); s = $urandom_range(4096);
               t = $urandom_range(4096); end
      endcase
      set_geometry(r, s, t);
   endtask

   // random vertices under the three idling patterns
   task automatic test_random_streams();
      send_idle_pct = 30; recv_idle_pct = 58;
      for (int g = 0; g < 6; g++) begin random_geometry(); random_phase(110); end
      send_idle_pct = 58; recv_idle_pct = 30;
      for (int g = 0; g < 6; g++) begin random_geometry(); random_phase(110); end
      send_idle_pct = 0; recv_idle_pct = 0;
      for (int g = 0; g < 6; g++) begin random_geometry(); random_phase(110); end
   endtask

   // long receiver hold-off fills the pipeline, then sender waits for drain
   task automatic test_backpressure();
      set_geometry(256, 36, 18);
      -> hold_off_start;
      random_phase(120);
      pause_until_drained();
      random_phase(40);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_reset_geometry();
      test_directed_extremes();
      test_backpressure();
      test_random_streams();
      wait_drained();
      if (mismatch_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: uv_sphere_vertex_generator_unit.f
rtl/uvsvg_pkg.sv
rtl/uv_sphere_vertex_generator_unit.sv
rtl/uvsvg_checker.sv
verif/testbench.sv
